/* rtl/setc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// setc_pkg - shared types for the edge trigger capture block
// Register indexes, register field widths and the settings record.
// ----------------------------------------------------------------------------
package setc_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 26;
  localparam int unsigned LevelW    = 10;
  localparam int unsigned FrameLenW = 26;
  localparam int unsigned DeltaW    = 16;
  localparam int unsigned OutTimeW  = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OBSERVED  = 3'd0,
    REG_SOURCE    = 3'd1,
    REG_SLOPE     = 3'd2,
    REG_LEVEL     = 3'd3,
    REG_FRAME_LEN = 3'd4,
    REG_ENABLED   = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    SLOPE_RISING  = 1'b0,
    SLOPE_FALLING = 1'b1
  } slope_e;

  typedef struct packed {
    logic [1:0]           observed;
    logic                 source;
    slope_e               slope;
    logic [LevelW-1:0]    level;
    logic [FrameLenW-1:0] frame_len;
    logic                 enabled;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    observed:  2'd1,
    source:    1'b0,
    slope:     SLOPE_RISING,
    level:     10'd410,
    frame_len: 26'd1000000,
    enabled:   1'b1
  };

endpackage
`default_nettype wire

/* rtl/setc_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// setc_cfg - settings registers
// Holds the trigger and frame settings; flags writes that end a frame.
// ----------------------------------------------------------------------------
module setc_cfg import setc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                     cfg_o,
  output logic                     stop_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d  = cfg_q;
    stop_o = 1'b0;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_OBSERVED: begin
          cfg_d.observed = cfg_data_i[1:0];
          stop_o         = 1'b1;
        end
        REG_SOURCE:    cfg_d.source    = cfg_data_i[0];
        REG_SLOPE:     cfg_d.slope     = slope_e'(cfg_data_i[0]);
        REG_LEVEL:     cfg_d.level     = cfg_data_i[LevelW-1:0];
        REG_FRAME_LEN: cfg_d.frame_len = cfg_data_i[FrameLenW-1:0];
        REG_ENABLED: begin
          cfg_d.enabled = cfg_data_i[0];
          stop_o        = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

/* rtl/setc_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// setc_core - trigger detection and frame timing
// Time accumulation, edge compare and frame bookkeeping for one word.
// ----------------------------------------------------------------------------
module setc_core import setc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 10,
  parameter int unsigned TIME_BITS   = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cfg_t                   cfg_i,
  input  wire logic                   stop_i,
  input  wire logic                   accept_i,
  input  wire logic [SAMPLE_BITS-1:0] ch1_raw_i,
  input  wire logic [SAMPLE_BITS-1:0] ch2_raw_i,
  input  wire logic [DeltaW-1:0]      delta_us_i,
  output logic                        push_o,
  output logic [SAMPLE_BITS-1:0]      ch1_value_o,
  output logic [SAMPLE_BITS-1:0]      ch2_value_o,
  output logic                        ch1_valid_o,
  output logic                        ch2_valid_o,
  output logic [OutTimeW-1:0]         sample_time_o,
  output logic                        first_o,
  output logic                        last_o
);

  localparam int unsigned CmpW = (SAMPLE_BITS > LevelW) ? SAMPLE_BITS : LevelW;
  localparam int unsigned LenW = (TIME_BITS > FrameLenW) ? TIME_BITS : FrameLenW;
  localparam int unsigned ExtW = (TIME_BITS > OutTimeW) ? TIME_BITS : OutTimeW;

  logic                   recording_q, recording_d;
  logic [TIME_BITS-1:0]   elapsed_q, elapsed_d;
  logic [SAMPLE_BITS-1:0] prev1_q, prev2_q;

  logic                   active;
  logic [TIME_BITS:0]     sum;
  logic [TIME_BITS-1:0]   sat;
  logic [CmpW-1:0]        prev_smp, now, level;
  logic                   crossing;
  logic                   reached;
  logic [ExtW-1:0]        time_ext;

  assign active = cfg_i.enabled && (cfg_i.observed != 2'd0);

  // saturating time add
  assign sum = {1'b0, elapsed_q} + (TIME_BITS+1)'(delta_us_i);
  assign sat = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];

  assign prev_smp = CmpW'(cfg_i.source ? prev2_q : prev1_q);
  assign now      = CmpW'(cfg_i.source ? ch2_raw_i : ch1_raw_i);
  assign level    = CmpW'(cfg_i.level);

  always_comb begin
    case (cfg_i.slope)
      SLOPE_RISING:  crossing = (prev_smp < level) && (now >= level);
      SLOPE_FALLING: crossing = (prev_smp > level) && (now <= level);
      default:       crossing = 1'b0;
    endcase
  end

  assign reached = LenW'(sat) >= LenW'(cfg_i.frame_len);

  always_comb begin
    recording_d = recording_q;
    elapsed_d   = elapsed_q;
    push_o      = 1'b0;
    first_o     = 1'b0;
    last_o      = 1'b0;
    time_ext    = ExtW'(sat);
    if (accept_i && active) begin
      elapsed_d = sat;
      if (recording_q) begin
        push_o = 1'b1;
        if (reached) begin
          recording_d = 1'b0;
          last_o      = 1'b1;
        end
      end else if (crossing) begin
        push_o      = 1'b1;
        first_o     = 1'b1;
        recording_d = 1'b1;
        elapsed_d   = '0;
        time_ext    = '0;
      end
    end
    if (stop_i) begin
      recording_d = 1'b0;
    end
  end

  assign ch1_valid_o   = cfg_i.observed[0];
  assign ch2_valid_o   = cfg_i.observed[1];
  assign ch1_value_o   = cfg_i.observed[0] ? ch1_raw_i : '0;
  assign ch2_value_o   = cfg_i.observed[1] ? ch2_raw_i : '0;
  assign sample_time_o = time_ext[OutTimeW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recording_q <= 1'b0;
      elapsed_q   <= '0;
      prev1_q     <= '0;
      prev2_q     <= '0;
    end else begin
      recording_q <= recording_d;
      elapsed_q   <= elapsed_d;
      if (accept_i && active) begin
        prev1_q <= ch1_raw_i;
        prev2_q <= ch2_raw_i;
      end
    end
  end

  a_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_o && first_o && last_o))
    else $error("frame start word marked last");

  a_stop_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_i |=> !recording_q)
    else $error("frame still running after settings write");

endmodule
`default_nettype wire

/* rtl/setc_out.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// setc_out - result register with skid stage
// Holds finished words for the output channel so intake keeps going.
// ----------------------------------------------------------------------------
module setc_out #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              full_o,
  output logic              valid_o,
  input  wire logic         stall_i,
  output logic [W-1:0]      data_o
);

  logic         main_valid_q, skid_valid_q;
  logic [W-1:0] main_q, skid_q;
  logic         main_free;

  assign main_free = !main_valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (main_free) begin
      main_valid_q <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_free) begin
      main_q <= skid_valid_q ? skid_q : data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  assign full_o  = skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid word without a result word ahead");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("word pushed into full buffer");

endmodule
`default_nettype wire

/* rtl/scope_edge_trigger_capture.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scope_edge_trigger_capture - edge trigger and frame capture
// Watches a two-channel sample stream for a level crossing and tags a frame.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_stall_o carries a sample pair and the
//   time since the previous pair; a word is taken when valid is high and
//   stall is low. one word can be taken every cycle while stall is low.
//   output channel: out_valid_o / out_stall_i carries at most one result
//   word per input word; a taken word goes into the result register, or
//   first into the skid stage while the receiver stalls. the trigger compare
//   and saturating time add sit between the input port and the result register,
//   so throughput is one word per cycle while in_stall_o is low. a skid stage
//   behind the result register lets the block take one more word while the
//   receiver stalls; in_stall_o rises only once both hold. settings are written
//   over cfg_we_i / cfg_idx_i / cfg_data_i; a write to the observed channels or
//   the enable drops any running frame. reset clears the frame state, elapsed
//   time and previous samples, and loads the default settings; no clearing pass is needed.
// ----------------------------------------------------------------------------
module scope_edge_trigger_capture import setc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 10,
  parameter int unsigned TIME_BITS   = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [CfgDataW-1:0]    cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0] ch1_raw_i,
  input  wire logic [SAMPLE_BITS-1:0] ch2_raw_i,
  input  wire logic [DeltaW-1:0]      delta_us_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [SAMPLE_BITS-1:0]      ch1_value_o,
  output logic [SAMPLE_BITS-1:0]      ch2_value_o,
  output logic                        ch1_valid_o,
  output logic                        ch2_valid_o,
  output logic [OutTimeW-1:0]         sample_time_us_o,
  output logic                        frame_first_o,
  output logic                        frame_last_o
);

  localparam int unsigned ResW = 2*SAMPLE_BITS + OutTimeW + 4;

  cfg_t                   cfg;
  logic                   stop;
  logic                   accept;
  logic                   push;
  logic                   full;
  logic [SAMPLE_BITS-1:0] r_ch1, r_ch2;
  logic                   r_v1, r_v2, r_first, r_last;
  logic [OutTimeW-1:0]    r_time;
  logic [ResW-1:0]        res_in, res_out;

  assign accept     = in_valid_i && !full;
  assign in_stall_o = full;

  setc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .stop_o     (stop)
  );

  setc_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .stop_i        (stop),
    .accept_i      (accept),
    .ch1_raw_i     (ch1_raw_i),
    .ch2_raw_i     (ch2_raw_i),
    .delta_us_i    (delta_us_i),
    .push_o        (push),
    .ch1_value_o   (r_ch1),
    .ch2_value_o   (r_ch2),
    .ch1_valid_o   (r_v1),
    .ch2_valid_o   (r_v2),
    .sample_time_o (r_time),
    .first_o       (r_first),
    .last_o        (r_last)
  );

  assign res_in = {r_ch1, r_ch2, r_v1, r_v2, r_time, r_first, r_last};

  setc_out #(
    .W (ResW)
  ) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res_in),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (res_out)
  );

  assign {ch1_value_o, ch2_value_o, ch1_valid_o, ch2_valid_o,
          sample_time_us_o, frame_first_o, frame_last_o} = res_out;

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the scope edge trigger capture block
// Drives sample pairs with random gaps and receiver stalls, predicts each
// captured word from a behavioural model of the trigger and frame logic,
// and compares every accepted result word in order.
// ----------------------------------------------------------------------------
module tb_top;
  import setc_pkg::*;

  localparam int unsigned SampleW    = 10;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned SampleMax  = (1 << SampleW) - 1;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned SettleWait = 4;
  localparam logic [FrameLenW-1:0] FrameMax = '1;
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  typedef struct packed {
    logic [SampleW-1:0]  ch1;
    logic [SampleW-1:0]  ch2;
    logic                ch1_ok;
    logic                ch2_ok;
    logic [OutTimeW-1:0] at_us;
    logic                is_first;
    logic                is_last;
  } capture_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic [SampleW-1:0] ch1_raw = '0;
  logic [SampleW-1:0] ch2_raw = '0;
  logic [DeltaW-1:0] delta_us = '0;
  logic out_stall = 1'b0;

  logic in_stall;
  logic out_valid;
  logic [SampleW-1:0] ch1_value;
  logic [SampleW-1:0] ch2_value;
  logic ch1_valid;
  logic ch2_valid;
  logic [OutTimeW-1:0] sample_time_us;
  logic frame_first;
  logic frame_last;

  // model state
  cfg_t scope_cfg = CfgReset;
  logic frame_open = 1'b0;
  logic [TimeW-1:0] time_acc = '0;
  logic [SampleW-1:0] last_ch1 = '0;
  logic [SampleW-1:0] last_ch2 = '0;
  capture_word_t pending_captures[$];

  int unsigned fail_count = 0;
  int hold_left = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  scope_edge_trigger_capture #(
    .SAMPLE_BITS(SampleW),
    .TIME_BITS  (TimeW)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .ch1_raw_i       (ch1_raw),
    .ch2_raw_i       (ch2_raw),
    .delta_us_i      (delta_us),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .ch1_value_o     (ch1_value),
    .ch2_value_o     (ch2_value),
    .ch1_valid_o     (ch1_valid),
    .ch2_valid_o     (ch2_valid),
    .sample_time_us_o(sample_time_us),
    .frame_first_o   (frame_first),
    .frame_last_o    (frame_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic string fmt_word(capture_word_t w);
    return $sformatf("ch1=%0d ch2=%0d valid=%b%b t=%0d first=%b last=%b",
                     w.ch1, w.ch2, w.ch1_ok, w.ch2_ok, w.at_us, w.is_first, w.is_last);
  endfunction

  task automatic note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  // trigger and frame behaviour for one accepted sample pair
  task automatic predict_capture(input logic [SampleW-1:0] c1, input logic [SampleW-1:0] c2,
                                 input logic [DeltaW-1:0] dt);
    logic [TimeW:0] sum;
    logic [SampleW-1:0] prior;
    logic [SampleW-1:0] cur;
    logic crossed;
    capture_word_t w;
    if (scope_cfg.enabled && scope_cfg.observed != 2'd0) begin
      sum = {1'b0, time_acc} + (TimeW+1)'(dt);
      time_acc = sum[TimeW] ? '1 : sum[TimeW-1:0];
      prior = scope_cfg.source ? last_ch2 : last_ch1;
      cur = scope_cfg.source ? c2 : c1;
      if (scope_cfg.slope == SLOPE_RISING) begin
        crossed = prior < scope_cfg.level && cur >= scope_cfg.level;
      end else begin
        crossed = prior > scope_cfg.level && cur <= scope_cfg.level;
      end
      w.ch1_ok = scope_cfg.observed[0];
      w.ch2_ok = scope_cfg.observed[1];
      w.ch1 = w.ch1_ok ? c1 : '0;
      w.ch2 = w.ch2_ok ? c2 : '0;
      w.is_first = 1'b0;
      w.is_last = 1'b0;
      if (frame_open) begin
        if (time_acc >= scope_cfg.frame_len) begin
          frame_open = 1'b0;
          w.is_last = 1'b1;
        end
        w.at_us = time_acc[OutTimeW-1:0];
        pending_captures.insert(pending_captures.size(), w);
      end else if (crossed) begin
        // trigger word opens the frame at time zero and is never last
        frame_open = 1'b1;
        time_acc = '0;
        w.at_us = '0;
        w.is_first = 1'b1;
        pending_captures.insert(pending_captures.size(), w);
      end
      last_ch1 = c1;
      last_ch2 = c2;
    end
  endtask

  always @(posedge clk) begin : monitor
    capture_word_t seen;
    capture_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen = '{ch1: ch1_value, ch2: ch2_value, ch1_ok: ch1_valid, ch2_ok: ch2_valid,
                 at_us: sample_time_us, is_first: frame_first, is_last: frame_last};
        if (pending_captures.size() == 0) begin
          note_fail({"unexpected word: ", fmt_word(seen)});
        end else begin
          want = pending_captures.pop_front();
          if (seen !== want) begin
            note_fail({"mismatch: expected ", fmt_word(want), " got ", fmt_word(seen)});
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_OBSERVED: begin
            scope_cfg.observed = cfg_data[1:0];
            frame_open = 1'b0;
          end
          REG_SOURCE:    scope_cfg.source = cfg_data[0];
          REG_SLOPE:     scope_cfg.slope = slope_e'(cfg_data[0]);
          REG_LEVEL:     scope_cfg.level = cfg_data[LevelW-1:0];
          REG_FRAME_LEN: scope_cfg.frame_len = cfg_data[FrameLenW-1:0];
          REG_ENABLED: begin
            scope_cfg.enabled = cfg_data[0];
            frame_open = 1'b0;
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_capture(ch1_raw, ch2_raw, delta_us);
      end
    end
  end

  // receiver: random stall bursts plus an occasional long hold-off
  initial begin : receiver
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(0, 15);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_word(input logic [SampleW-1:0] c1, input logic [SampleW-1:0] c2,
                           input logic [DeltaW-1:0] dt);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 15)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    ch1_raw <= c1;
    ch2_raw <= c2;
    delta_us <= dt;
    do @(posedge clk); while (in_stall);
  endtask

  // wait until every predicted word is out and the pipe has emptied
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_captures.size() != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);
  endtask

  // register value with random junk above the field
  function automatic logic [CfgDataW-1:0] with_junk(int unsigned val, int unsigned w);
    logic [CfgDataW-1:0] mask;
    mask = (CfgDataW'(1) << w) - CfgDataW'(1);
    return (CfgDataW'($urandom) & ~mask) | (CfgDataW'(val) & mask);
  endfunction

  function automatic logic [SampleW-1:0] near_level(logic [LevelW-1:0] lvl);
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, SampleMax);
      1: v = lvl;
      default: v = int'(lvl) + int'($urandom_range(0, 64)) - 32;
    endcase
    if (v < 0) v = 0;
    if (v > int'(SampleMax)) v = SampleMax;
    return v[SampleW-1:0];
  endfunction

  task automatic test_defaults();
    send_word(10'd0, 10'd0, 16'd0);
    send_word(10'd410, 10'd1023, 16'hFFFF);
    send_word(10'd1023, 10'd0, 16'd0);
    send_word(10'd0, 10'd1023, 16'hFFFF);
    settle();
  endtask

  task automatic test_frame_zero();
    write_reg(REG_OBSERVED, 26'd3);
    write_reg(REG_SOURCE, 26'd1);
    write_reg(REG_SLOPE, 26'(SLOPE_FALLING));
    write_reg(REG_LEVEL, 26'd0);
    write_reg(REG_FRAME_LEN, 26'd0);
    send_word(10'd5, 10'd5, 16'd100);
    send_word(10'd7, 10'd0, 16'd9);
    send_word(10'd1023, 10'd1023, 16'd0);
    settle();
  endtask

  task automatic test_unobserved_source();
    write_reg(REG_OBSERVED, 26'd2);
    write_reg(REG_SOURCE, 26'd0);
    write_reg(REG_SLOPE, 26'(SLOPE_RISING));
    write_reg(REG_LEVEL, 26'd512);
    write_reg(REG_FRAME_LEN, 26'd100);
    send_word(10'd100, 10'd1, 16'd50);
    send_word(10'd600, 10'd777, 16'd50);
    send_word(10'd0, 10'd1023, 16'd100);
    settle();
  endtask

  task automatic test_inactive();
    write_reg(REG_OBSERVED, 26'd1);
    write_reg(REG_FRAME_LEN, 26'd1000);
    send_word(10'd600, 10'd0, 16'd0);
    settle();
    // disabled block must keep its previous samples untouched
    write_reg(REG_ENABLED, 26'd0);
    send_word(10'd0, 10'd0, 16'd10);
    send_word(10'd600, 10'd0, 16'd10);
    settle();
    write_reg(REG_ENABLED, 26'd1);
    send_word(10'd600, 10'd0, 16'd10);
    settle();
    write_reg(REG_OBSERVED, 26'd0);
    send_word(10'd0, 10'd0, 16'd10);
    settle();
    write_reg(REG_OBSERVED, 26'd1);
    send_word(10'd700, 10'd0, 16'd10);
    send_word(10'd0, 10'd0, 16'd10);
    send_word(10'd1023, 10'd0, 16'd10);
    settle();
  endtask

  task automatic test_spare_index();
    write_reg(RegSpareLo, '1);
    write_reg(RegSpareHi, '1);
    send_word(10'd0, 10'd0, 16'd1);
    send_word(10'd1023, 10'd1023, 16'd1);
    settle();
  endtask

  task automatic test_backpressure();
    write_reg(REG_OBSERVED, 26'd3);
    write_reg(REG_LEVEL, 26'd512);
    write_reg(REG_FRAME_LEN, FrameMax);
    tx_idle = 1'b0;
    hold_left = 40;
    send_word(10'd0, 10'd0, 16'd1);
    send_word(10'd600, 10'd300, 16'd1);
    repeat (22) begin
      send_word(10'($urandom), 10'($urandom), 16'($urandom_range(0, 3)));
    end
    settle();
    tx_idle = 1'b1;
  endtask

  task automatic run_random_phase(input int n_items);
    logic [1:0] obs;
    logic [LevelW-1:0] lvl;
    logic [FrameLenW-1:0] flen;
    logic [DeltaW-1:0] dt;
    int unsigned dt_cap;
    obs = 2'($urandom_range(1, 3));
    case ($urandom_range(0, 5))
      0: lvl = '0;
      1: lvl = '1;
      default: lvl = LevelW'($urandom_range(0, SampleMax));
    endcase
    case ($urandom_range(0, 5))
      0: flen = '0;
      1: flen = FrameMax;
      2: flen = FrameLenW'($urandom_range(1, 400000));
      default: flen = FrameLenW'($urandom_range(1, 3000));
    endcase
    write_reg(REG_SOURCE, with_junk($urandom_range(0, 1), 1));
    write_reg(REG_SLOPE, with_junk($urandom_range(0, 1), 1));
    write_reg(REG_LEVEL, with_junk(lvl, LevelW));
    write_reg(REG_FRAME_LEN, flen);
    write_reg(REG_ENABLED, with_junk(1, 1));
    write_reg(REG_OBSERVED, with_junk(obs, 2));
    if ($urandom_range(0, 3) == 0) begin
      // park the block for a while; these words must be ignored
      if ($urandom_range(0, 1) == 1) begin
        write_reg(REG_ENABLED, with_junk(0, 1));
      end else begin
        write_reg(REG_OBSERVED, with_junk(0, 2));
      end
      repeat (12) begin
        send_word(10'($urandom), 10'($urandom), 16'($urandom));
      end
      settle();
      write_reg(REG_ENABLED, with_junk(1, 1));
      write_reg(REG_OBSERVED, with_junk(obs, 2));
    end
    if ($urandom_range(0, 7) == 0) begin
      write_reg($urandom_range(0, 1) ? RegSpareLo : RegSpareHi, CfgDataW'($urandom));
    end
    dt_cap = (flen >> 3) + 1;
    if (dt_cap > 16'hFFFF) dt_cap = 16'hFFFF;
    repeat (n_items) begin
      case ($urandom_range(0, 7))
        0: dt = '0;
        1: dt = '1;
        2: dt = DeltaW'($urandom_range(0, 16'hFFFF));
        default: dt = DeltaW'($urandom_range(0, dt_cap));
      endcase
      send_word(near_level(lvl), near_level(lvl), dt);
    end
    settle();
  endtask

  task automatic test_random();
    for (int k = 0; k < 9; k++) begin
      // some phases run flat out on one or both sides; the last has no gaps
      tx_idle = !(k == 2 || k == 5 || k >= 8);
      rx_idle = !(k == 2 || k == 4 || k >= 8);
      run_random_phase(150);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_defaults();
    test_frame_zero();
    test_unobserved_source();
    test_inactive();
    test_spare_index();
    test_backpressure();
    test_random();
    if (pending_captures.size() != 0) begin
      note_fail($sformatf("%0d expected words never arrived", pending_captures.size()));
    end
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
